// File: hdl/alarm_table_scheduler_top_assert.svh
// Assertion macros for the alarm table scheduler.
`ifndef ALARM_TABLE_SCHEDULER_TOP_ASSERT_SVH
`define ALARM_TABLE_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ATS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ATS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ats_pkg.sv
package ats_pkg;

  localparam int SLOT_COUNT_DEF = 6;
  localparam int KEY_W          = 27;

  localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
  localparam logic [6:0] YEAR_MAX        = 7'd99;

  localparam logic [1:0] RPT_ONCE  = 2'd0;
  localparam logic [1:0] RPT_DAILY = 2'd1;

  localparam logic [2:0] DAILY_STEPS  = 3'd1;
  localparam logic [2:0] WEEKLY_STEPS = 3'd7;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_DELETE  = 2'd1,
    OP_SCAN    = 2'd2,
    OP_DISMISS = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_HEAD,
    ST_DIS_READ,
    ST_DIS_STEP,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // One table entry; the enable flag lives in flip-flops next to the memory.
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
    logic [1:0] rpt;
  } alarm_t;

  // Non-leap month lengths; months outside 1..12 count as 31 days.
  function automatic logic [4:0] month_len(logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Ordering key: year, month, day, hour, minute.
  function automatic logic [KEY_W-1:0] alarm_key(alarm_t a);
    return {a.year, a.month, a.day, a.hour, a.minute};
  endfunction

  function automatic alarm_t add_day(alarm_t a);
    alarm_t     r;
    logic [5:0] nd;
    logic [4:0] mo;
    r  = a;
    nd = {1'b0, a.day} + 6'd1;
    mo = {1'b0, a.month};
    if (nd > {1'b0, month_len(a.month)}) begin
      nd = 6'd1;
      mo = mo + 5'd1;
      if (mo > {1'b0, MONTHS_PER_YEAR}) begin
        mo = 5'd1;
        if (a.year < YEAR_MAX) begin
          r.year = a.year + 7'd1;
        end
      end
    end
    r.day   = nd[4:0];
    r.month = mo[3:0];
    return r;
  endfunction

endpackage

// File: hdl/alarm_table_scheduler_top.sv
// Alarm table scheduler: a table of SLOT_COUNT alarm slots kept in one
// synchronous memory (one write port, one read port, registered read data),
// with the per-slot enable and written flags in flip-flops, so reset takes
// effect at once with no clearing pass. Each item is one operation: write,
// delete, scan against the current date and time, or dismiss. Every item
// yields exactly one result (head_valid, head_slot, alarm_due, active_count).
// After every operation the block sweeps the whole table through the single
// read port, one slot a cycle, applying the scan update on the fly and
// picking the earliest enabled slot as the new head (lower index wins a tie).
// A write, a delete or a dismiss of an out-of-range slot goes straight into
// the sweep. A scan first reads the head entry to flag alarm_due. A dismiss
// first reads the slot: a once slot is disabled, a daily slot moves one day
// ahead and a weekly slot seven, in seven day steps, and the new date is
// written back. The result goes valid in the same cycle that the sequencer
// is back in idle and can take the next item; no item is taken before then.
// in_ready is high whenever the sequencer is idle, even while a previous
// result still waits in the output register.
module alarm_table_scheduler_top
  import ats_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] operation,
  input  logic [2:0] slot,
  input  logic [4:0] hour,
  input  logic [5:0] minute,
  input  logic [4:0] day,
  input  logic [3:0] month,
  input  logic [6:0] year,
  input  logic [1:0] repeat_mode,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       head_valid,
  output logic [2:0] head_slot,
  output logic       alarm_due,
  output logic [2:0] active_count
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [CNT_W-1:0] SLOTS_C  = CNT_W'(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  state_t state, state_next;

  // table memory
  alarm_t           mem [SLOT_COUNT];
  alarm_t           rdata;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic             we;
  alarm_t           wdata;

  logic [SLOT_COUNT-1:0] enable, enable_next;
  logic [SLOT_COUNT-1:0] written, written_next;

  // item held for the duration of the operation
  op_t              op_r;
  logic [IDX_W-1:0] slot_r;
  logic [KEY_W-1:0] now_key;
  logic             due_r;
  logic             slot_ok;
  logic [IDX_W-1:0] slot_idx;

  // dismiss day stepping
  alarm_t     work;
  logic [2:0] steps;
  alarm_t     dis_ent;

  // sweep
  logic [CNT_W-1:0] cnt;
  logic             proc_vld;
  logic [IDX_W-1:0] proc_idx;
  logic             found;
  logic [IDX_W-1:0] best_idx;
  logic [KEY_W-1:0] best_key;
  logic [CNT_W-1:0] act_cnt;
  alarm_t           proc_ent, proc_upd;
  logic [KEY_W-1:0] proc_key, upd_key;
  logic             proc_en, proc_en_new, proc_wr;

  logic [IDX_W-1:0] head_index;
  logic             head_present;

  logic in_accept, sweep_start, out_load;

  assign in_accept = in_valid && in_ready;
  assign slot_ok   = 32'(slot) < SLOT_COUNT;
  assign slot_idx  = IDX_W'(slot);

  // Never-written entries read as the reset value (all zero).
  assign dis_ent  = written[slot_r]   ? rdata : '0;
  assign proc_ent = written[proc_idx] ? rdata : '0;
  assign proc_key = alarm_key(proc_ent);
  assign proc_en  = enable[proc_idx];
  assign upd_key  = alarm_key(proc_upd);

  // Scan update of the slot under the sweep: an exact match goes off, a past
  // alarm moves one day ahead and is written back.
  always_comb begin
    proc_upd    = proc_ent;
    proc_en_new = proc_en;
    proc_wr     = 1'b0;
    if (op_r == OP_SCAN && proc_en) begin
      if (proc_key == now_key) begin
        proc_en_new = 1'b0;
      end else if (proc_key < now_key) begin
        proc_upd = add_day(proc_ent);
        proc_wr  = 1'b1;
      end
    end
  end

  // Sequencer: next state, memory port control, flag updates.
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    we           = 1'b0;
    waddr        = proc_idx;
    wdata        = proc_upd;
    raddr        = cnt[IDX_W-1:0];
    enable_next  = enable;
    written_next = written;
    sweep_start  = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        // head entry for a scan, target slot for a dismiss
        raddr = (op_t'(operation) == OP_SCAN) ? head_index : slot_idx;
        if (in_valid) begin
          unique case (op_t'(operation))
            OP_WRITE: begin
              if (slot_ok) begin
                we    = 1'b1;
                waddr = slot_idx;
                wdata = '{hour: hour, minute: minute, day: day, month: month,
                          year: year, rpt: repeat_mode};
                enable_next[slot_idx]  = 1'b1;
                written_next[slot_idx] = 1'b1;
              end
              sweep_start = 1'b1;
              state_next  = ST_SWEEP;
            end
            OP_DELETE: begin
              if (slot_ok) begin
                enable_next[slot_idx] = 1'b0;
              end
              sweep_start = 1'b1;
              state_next  = ST_SWEEP;
            end
            OP_SCAN: begin
              state_next = ST_SCAN_HEAD;
            end
            OP_DISMISS: begin
              if (slot_ok) begin
                state_next = ST_DIS_READ;
              end else begin
                sweep_start = 1'b1;
                state_next  = ST_SWEEP;
              end
            end
          endcase
        end
      end
      ST_SCAN_HEAD: begin
        sweep_start = 1'b1;
        state_next  = ST_SWEEP;
      end
      ST_DIS_READ: begin
        if (dis_ent.rpt == RPT_ONCE) begin
          enable_next[slot_r] = 1'b0;
          sweep_start         = 1'b1;
          state_next          = ST_SWEEP;
        end else begin
          state_next = ST_DIS_STEP;
        end
      end
      ST_DIS_STEP: begin
        if (steps == DAILY_STEPS) begin
          we                   = 1'b1;
          waddr                = slot_r;
          wdata                = add_day(work);
          written_next[slot_r] = 1'b1;
          sweep_start          = 1'b1;
          state_next           = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (proc_vld) begin
          we                    = proc_wr;
          enable_next[proc_idx] = proc_en_new;
          if (proc_idx == LAST_IDX) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      enable  <= '0;
      written <= '0;
    end else begin
      state   <= state_next;
      enable  <= enable_next;
      written <= written_next;
    end
  end

  // Table memory. A write always lands before any read of the same slot
  // is issued, so no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Item registers and the dismiss stepper.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r    <= op_t'(operation);
      slot_r  <= slot_idx;
      now_key <= {year, month, day, hour, minute};
      due_r   <= 1'b0;
    end
    if (state == ST_SCAN_HEAD) begin
      due_r <= head_present && (alarm_key(rdata) == now_key);
    end
    if (state == ST_DIS_READ) begin
      work  <= dis_ent;
      steps <= (dis_ent.rpt == RPT_DAILY) ? DAILY_STEPS : WEEKLY_STEPS;
    end else if (state == ST_DIS_STEP) begin
      work  <= add_day(work);
      steps <= steps - 3'd1;
    end
  end

  // Sweep: read issue counter, processing stage, head search.
  always_ff @(posedge clk) begin
    if (rst) begin
      proc_vld <= 1'b0;
      cnt      <= '0;
    end else if (sweep_start) begin
      proc_vld <= 1'b0;
      cnt      <= '0;
    end else if (state == ST_SWEEP) begin
      proc_vld <= cnt < SLOTS_C;
      if (cnt < SLOTS_C) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_start) begin
      found    <= 1'b0;
      best_idx <= '0;
      best_key <= '0;
      act_cnt  <= '0;
    end else if (state == ST_SWEEP) begin
      proc_idx <= cnt[IDX_W-1:0];
      if (proc_vld && proc_en_new) begin
        act_cnt <= act_cnt + CNT_W'(1);
        if (!found || upd_key < best_key) begin
          found    <= 1'b1;
          best_idx <= proc_idx;
          best_key <= upd_key;
        end
      end
    end
  end

  // Result register and head state.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      head_valid   <= 1'b0;
      head_slot    <= '0;
      alarm_due    <= 1'b0;
      active_count <= '0;
      head_present <= 1'b0;
      head_index   <= '0;
    end else if (out_load) begin
      out_valid    <= 1'b1;
      head_valid   <= found;
      head_slot    <= found ? 3'(best_idx) : 3'd0;
      alarm_due    <= due_r;
      active_count <= 3'(act_cnt);
      head_present <= found;
      head_index   <= found ? best_idx : '0;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`include "alarm_table_scheduler_top_assert.svh"

  `ATS_ASSERT_SAME(a_head_tracks_enable, state == ST_IDLE, head_present == (|enable), "head flag disagrees with enable bits")
  `ATS_ASSERT_SAME(a_head_enabled, (state == ST_IDLE) && head_present, enable[head_index], "head slot is not enabled")
  `ATS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item accepted while busy")
  `ATS_ASSERT_SAME(a_sweep_write_scan, (state == ST_SWEEP) && we, proc_vld && (op_r == OP_SCAN), "stray table write in sweep")
  `ATS_ASSERT_NEXT(a_done_releases, (state == ST_DONE) && (!out_valid || out_ready), out_valid && (state == ST_IDLE), "result not loaded at end of sweep")

endmodule
